[rtl/isdc_pkg.sv]
// Shared types and constants of the I2C register target with DAC control.
package isdc_pkg;

  // Register addresses seen on the bus.
  localparam logic [7:0] REG_DAC_HV     = 8'h10;
  localparam logic [7:0] REG_ADC_HV     = 8'h11;
  localparam logic [7:0] REG_DAC_OFFSET = 8'h20;
  localparam logic [7:0] REG_DAC_LED    = 8'h30;
  localparam logic [7:0] REG_ADC_LOW    = 8'h31;
  localparam logic [7:0] REG_ADC_HIGH   = 8'h32;
  localparam logic [7:0] REG_DAC_GAIN   = 8'h40;

  localparam logic [15:0] UNKNOWN_READ   = 16'hFFFF;
  localparam logic [11:0] HI_NIBBLE_MASK = 12'hF00;

  // DAC chip selects and channels.
  localparam logic [1:0] CHIP_HV     = 2'd0;
  localparam logic [1:0] CHIP_OFFSET = 2'd1;
  localparam logic [1:0] CHIP_LED    = 2'd2;
  localparam logic       CH_A        = 1'b0;
  localparam logic       CH_B        = 1'b1;

  // Command queue between the decoder and the result sequencer.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,  // no transaction in progress
    PH_REG  = 2'd1,  // write address seen, register byte expected
    PH_LOW  = 2'd2,  // low data byte expected, or read value loaded
    PH_HIGH = 2'd3   // high data byte expected
  } phase_t;

  // One decoded event: everything the sequencer needs to emit its beats.
  typedef struct packed {
    logic        tx_load;
    logic [7:0]  tx_byte;
    logic        led;
    logic        dac_load;
    logic        two_frames;
    logic [1:0]  chip;
    logic        channel;
    logic [11:0] code_a;  // high-nibble frame when two frames are sent
    logic [11:0] code_b;  // the only or the second frame
  } cmd_t;

endpackage

[rtl/isdc_ifs.sv]
// Handshake channels: bus byte events in, result beats out.
interface isdc_evt_if #(
  parameter int ADC_BITS = 10
);
  logic                valid;
  logic                ready;
  logic                is_read;
  logic                is_data;
  logic [7:0]          rx_byte;
  logic [ADC_BITS-1:0] adc_low_amp;
  logic [ADC_BITS-1:0] adc_high_amp;
  logic [ADC_BITS-1:0] adc_hv_feedback;

  modport source (output valid, is_read, is_data, rx_byte, adc_low_amp, adc_high_amp,
                  adc_hv_feedback, input ready);
  modport sink (input valid, is_read, is_data, rx_byte, adc_low_amp, adc_high_amp,
                adc_hv_feedback, output ready);
endinterface

interface isdc_res_if;
  logic        valid;
  logic        ready;
  logic        tx_load;
  logic [7:0]  tx_byte;
  logic        dac_load;
  logic [1:0]  dac_chip;
  logic        dac_channel;
  logic [11:0] dac_code;
  logic        activity_led;
  logic        last;

  modport source (output valid, tx_load, tx_byte, dac_load, dac_chip, dac_channel, dac_code,
                  activity_led, last, input ready);
  modport sink (input valid, tx_load, tx_byte, dac_load, dac_chip, dac_channel, dac_code,
                activity_led, last, output ready);
endinterface

[rtl/isdc_queue.sv]
// Small command queue between the event decoder and the result sequencer.
module isdc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  isdc_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output isdc_pkg::cmd_t pop_cmd,
  output logic           empty
);

  isdc_pkg::cmd_t                  slots [isdc_pkg::QUEUE_DEPTH];
  logic [isdc_pkg::QPTR_BITS-1:0]  wr_ptr;
  logic [isdc_pkg::QPTR_BITS-1:0]  rd_ptr;
  logic [isdc_pkg::QPTR_BITS:0]    count;

  assign full    = (count == (isdc_pkg::QPTR_BITS+1)'(isdc_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
      count <= (isdc_pkg::QPTR_BITS+1)'(isdc_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

[rtl/isdc_front.sv]
// Event decoder: takes bus byte events, keeps the transaction state, emits commands.
module isdc_front #(
  parameter int DAC_BITS = 12,
  parameter int ADC_BITS = 10
) (
  input  logic           clk,
  input  logic           rst,
  isdc_evt_if.sink       bus_evt,
  input  logic           full,
  output logic           push,
  output isdc_pkg::cmd_t cmd
);

  localparam logic [11:0] DAC_MASK =
      (DAC_BITS >= 12) ? 12'hFFF : 12'((1 << DAC_BITS) - 1);
  localparam logic [15:0] ADC_MASK =
      (ADC_BITS >= 16) ? 16'hFFFF : 16'((1 << ADC_BITS) - 1);

  isdc_pkg::phase_t phase;
  isdc_pkg::phase_t phase_next;
  logic [7:0]       reg_select;
  logic [7:0]       reg_select_next;
  logic [15:0]      data_accum;
  logic [15:0]      data_accum_next;
  logic             led_level;

  logic [15:0] sum_low;
  logic [15:0] value;
  logic [15:0] sample;
  logic [11:0] code_hi;
  logic [11:0] code_lo;

  assign bus_evt.ready = !full;
  assign push          = bus_evt.valid && !full;

  assign sum_low = data_accum + {8'h00, bus_evt.rx_byte};
  assign value   = data_accum + {bus_evt.rx_byte, 8'h00};
  assign code_hi = value[15:4] & isdc_pkg::HI_NIBBLE_MASK & DAC_MASK;
  assign code_lo = value[11:0] & DAC_MASK;

  always_comb begin
    case (reg_select)
      isdc_pkg::REG_ADC_HV:   sample = 16'(bus_evt.adc_hv_feedback) & ADC_MASK;
      isdc_pkg::REG_ADC_LOW:  sample = 16'(bus_evt.adc_low_amp) & ADC_MASK;
      isdc_pkg::REG_ADC_HIGH: sample = 16'(bus_evt.adc_high_amp) & ADC_MASK;
      default:                sample = isdc_pkg::UNKNOWN_READ;
    endcase
  end

  always_comb begin
    phase_next      = phase;
    reg_select_next = reg_select;
    data_accum_next = data_accum;
    cmd             = '0;
    cmd.led         = !led_level;
    if (bus_evt.is_read) begin
      if (!bus_evt.is_data) begin
        data_accum_next = sample;
        phase_next      = isdc_pkg::PH_LOW;
        cmd.tx_load     = 1'b1;
        cmd.tx_byte     = sample[15:8];
      end else begin
        if (phase == isdc_pkg::PH_LOW) begin
          cmd.tx_load = 1'b1;
          cmd.tx_byte = data_accum[7:0];
        end else begin
          data_accum_next = '0;
        end
        phase_next      = isdc_pkg::PH_IDLE;
        reg_select_next = '0;
      end
    end else if (!bus_evt.is_data) begin
      phase_next      = isdc_pkg::PH_REG;
      data_accum_next = '0;
    end else begin
      unique case (phase)
        isdc_pkg::PH_REG: begin
          reg_select_next = bus_evt.rx_byte;
          phase_next      = isdc_pkg::PH_LOW;
        end
        isdc_pkg::PH_LOW: begin
          data_accum_next = sum_low;
          phase_next      = isdc_pkg::PH_HIGH;
        end
        isdc_pkg::PH_HIGH: begin
          reg_select_next = '0;
          data_accum_next = '0;
          phase_next      = isdc_pkg::PH_IDLE;
          cmd.code_a      = code_hi;
          cmd.code_b      = code_lo;
          case (reg_select)
            isdc_pkg::REG_DAC_HV: begin
              cmd.dac_load   = 1'b1;
              cmd.two_frames = 1'b1;
              cmd.chip       = isdc_pkg::CHIP_HV;
              cmd.channel    = isdc_pkg::CH_A;
            end
            isdc_pkg::REG_DAC_OFFSET: begin
              cmd.dac_load   = 1'b1;
              cmd.two_frames = 1'b1;
              cmd.chip       = isdc_pkg::CHIP_OFFSET;
              cmd.channel    = isdc_pkg::CH_B;
            end
            isdc_pkg::REG_DAC_LED: begin
              cmd.dac_load = 1'b1;
              cmd.chip     = isdc_pkg::CHIP_LED;
              cmd.channel  = isdc_pkg::CH_A;
            end
            isdc_pkg::REG_DAC_GAIN: begin
              cmd.dac_load = 1'b1;
              cmd.chip     = isdc_pkg::CHIP_LED;
              cmd.channel  = isdc_pkg::CH_B;
            end
            default: begin
              // Unknown register: the value is dropped without a frame.
              cmd.code_a = '0;
              cmd.code_b = '0;
            end
          endcase
        end
        isdc_pkg::PH_IDLE: begin
          data_accum_next = '0;
          phase_next      = isdc_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= isdc_pkg::PH_IDLE;
      reg_select <= '0;
      data_accum <= '0;
      led_level  <= 1'b0;
    end else if (push) begin
      phase      <= phase_next;
      reg_select <= reg_select_next;
      data_accum <= data_accum_next;
      led_level  <= !led_level;
    end
  end

  a_read_addr_loads: assert property (@(posedge clk) disable iff (rst)
      push && bus_evt.is_read && !bus_evt.is_data |=> phase == isdc_pkg::PH_LOW)
    else $error("read address did not load the transmit value");
  a_frame_only_on_high: assert property (@(posedge clk) disable iff (rst)
      push && cmd.dac_load |-> phase == isdc_pkg::PH_HIGH && !cmd.tx_load)
    else $error("DAC frame issued outside the high data byte");

endmodule

[rtl/isdc_back.sv]
// Result sequencer: turns queued commands into one or two registered result beats.
module isdc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  isdc_pkg::cmd_t cmd,
  output logic           pop,
  isdc_res_if.source     result
);

  logic second;
  logic load;
  logic split_first;

  assign load        = !empty && (!result.valid || result.ready);
  assign split_first = cmd.two_frames && !second;
  assign pop         = load && !split_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      second       <= 1'b0;
    end else begin
      if (load) begin
        result.valid <= 1'b1;
        second       <= split_first;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.tx_load      <= cmd.tx_load;
      result.tx_byte      <= cmd.tx_byte;
      result.dac_load     <= cmd.dac_load;
      result.dac_chip     <= cmd.chip;
      result.activity_led <= cmd.led;
      result.last         <= !split_first;
      // The second frame of a pair goes to the other channel of the same chip.
      result.dac_channel  <= second ? !cmd.channel : cmd.channel;
      result.dac_code     <= split_first ? cmd.code_a : cmd.code_b;
    end
  end

  a_first_of_pair: assert property (@(posedge clk) disable iff (rst)
      result.valid && !result.last |-> result.dac_load && !result.tx_load)
    else $error("non-final beat without a DAC frame");
  a_pair_completes: assert property (@(posedge clk) disable iff (rst)
      load && split_first |=> second && !empty)
    else $error("second frame of a pair lost");

endmodule

[rtl/i2c_register_slave_dac_control.sv]
// Top level of the I2C register target with DAC control.
//
//  channel   modport  beat carries
//  bus_evt   sink     one completed I2C byte event plus three ADC samples
//  result    source   transmit byte and/or one DAC frame, activity LED, last
//
// An event is decoded in the cycle it is accepted and queued; its results
// pass through the command queue into the output register.
// Events without a frame or with one frame give one result beat; a split write
// to a two-frame register gives two beats, one frame per result beat.
// A two-entry command queue lets the decoder keep accepting while results stall.
// Synchronous reset clears the transaction state, the queue and the output valid.
module i2c_register_slave_dac_control #(
  parameter int DAC_BITS = 12,
  parameter int ADC_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  isdc_evt_if.sink    bus_evt,
  isdc_res_if.source  result
);

  logic           push;
  logic           full;
  logic           pop;
  logic           empty;
  isdc_pkg::cmd_t push_cmd;
  isdc_pkg::cmd_t pop_cmd;

  isdc_front #(
    .DAC_BITS (DAC_BITS),
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .bus_evt (bus_evt),
    .full    (full),
    .push    (push),
    .cmd     (push_cmd)
  );

  isdc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  isdc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (empty),
    .cmd    (pop_cmd),
    .pop    (pop),
    .result (result)
  );

endmodule
